/* src/wpdb_pkg.sv */
`timescale 1ns / 1ps
// Shared package for the windowed power dB level mapper.
// Holds defaults, register indexes, sequencer states, constants and a Q30 helper.
// No dependencies.
package wpdb_pkg;

  // Parameter defaults.
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int WINDOW_BITS_DEF = 16;
  localparam int SINE_DEPTH_DEF  = 1024;

  // Configuration port.
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CALIBRATE,
    CFG_PHASE_STEP,
    CFG_PERIOD,
    CFG_WINDOW,
    CFG_LOWER,
    CFG_UPPER
  } cfg_index_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PHASE,
    S_X2,
    S_POLY,
    S_Y,
    S_SQUARE,
    S_LOG_NORM,
    S_LOG_SQR,
    S_DB,
    S_CMP,
    S_MAP,
    S_DIV,
    S_LVL,
    S_OUT
  } state_t;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  // dB arithmetic.
  localparam int DB_W     = 18;
  localparam int SUM_W    = 62;
  localparam int LOG_FRAC = 16;
  localparam logic signed [DB_W-1:0] DB_FLOOR = -18'sd131072;
  localparam logic [MUL_W-1:0] DB_PER_BIT_Q24 = 34'd101008905;

  // Quarter-wave sine polynomial coefficients in Q30, highest order first.
  localparam logic signed [32:0] POLY_COEF [0:5] = '{
    -33'sd3864,
    33'sd172272,
    -33'sd5026995,
    33'sd85569306,
    -33'sd693598669,
    33'sd1686629713
  };

  // Q30 product scaled back, truncating toward zero.
  function automatic logic signed [37:0] qmul_q30(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] adj;
    adj = v + (v[PROD_W-1] ? 68'sd1073741823 : 68'sd0);
    return adj[67:30];
  endfunction

endpackage

/* src/windowed_power_db_level_mapper.sv */
`timescale 1ns / 1ps
// Windowed power dB level mapper: tone generator, power window, log, dB and level map.
// Depends on wpdb_pkg.
//
// A sample inside a window passes through the tone multiplies and the square; a window end
// can add two log2 passes of 6 normalize steps and 16 squarings, the dB scale, and an
// 8-step level divide. One sample is in flight at a time: a new one is stalled until the
// result is issued. All products come from the single shared 34x34 multiplier.
// Reset (synchronous, active high) restores register defaults and clears all window state.
module windowed_power_db_level_mapper #(
  parameter int SAMPLE_BITS      = wpdb_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_BITS      = wpdb_pkg::WINDOW_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = wpdb_pkg::SINE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [wpdb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [wpdb_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]          return_sample,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [SAMPLE_BITS-1:0]          tone_sample,
  output logic                                   level_valid,
  output logic [7:0]                             level,
  output logic                                   db_valid,
  output logic signed [wpdb_pkg::DB_W-1:0]       level_db
);

  localparam int LD     = $clog2(SINE_TABLE_DEPTH);
  localparam int MW     = wpdb_pkg::MUL_W;
  localparam int PW     = wpdb_pkg::PROD_W;
  localparam int SB     = SAMPLE_BITS;
  localparam int WB     = WINDOW_BITS;
  localparam logic signed [23:0] LOG_OFFSET = 24'((2 * (SB - 1)) << wpdb_pkg::LOG_FRAC);
  localparam logic [63:0] TONE_FULL = (64'd1 << (SB - 1)) - 64'd1;

  // Configuration registers.
  logic                 calibrate_mode;
  logic [23:0]          tone_phase_step;
  logic [15:0]          tone_period;
  logic [WB-1:0]        window_length;
  logic signed [17:0]   lower_db;
  logic signed [17:0]   upper_db;

  // Persistent state.
  logic [15:0]          tone_index;
  logic [WB-1:0]        window_count;
  logic [61:0]          window_sum;
  logic signed [17:0]   last_db;
  logic [7:0]           last_level;

  // Sequencer.
  wpdb_pkg::state_t     state, state_next;
  logic                 mul_wait;
  logic [4:0]           step;

  // Working registers.
  logic signed [SB-1:0] samp;
  logic [1:0]           quad;
  logic [30:0]          x;
  logic [30:0]          x2;
  logic signed [32:0]   p;
  logic signed [SB-1:0] tone;
  logic signed [PW-1:0] prod;
  logic [63:0]          norm;
  logic [5:0]           zcnt;
  logic [5:0]           nlog;
  logic [31:0]          lm;
  logic [15:0]          frac;
  logic                 log_sel;
  logic [21:0]          log_a;
  logic signed [23:0]   dlog;
  logic signed [17:0]   db;
  logic [29:0]          rem;
  logic [29:0]          dsh;
  logic [7:0]           quo;
  logic [7:0]           lv;
  logic                 pend_db_valid;
  logic                 pend_lv_valid;

  // Shared multiplier.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  logic accept;
  logic out_free;
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;
  assign sample_stall = rst || (state != wpdb_pkg::S_IDLE);

  // Multiplier operand selection by sequencer state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      wpdb_pkg::S_PHASE: begin
        mul_a = $signed({{(MW-16){1'b0}}, tone_index});
        mul_b = $signed({{(MW-24){1'b0}}, tone_phase_step});
      end
      wpdb_pkg::S_X2: begin
        mul_a = $signed({3'b0, x});
        mul_b = $signed({3'b0, x});
      end
      wpdb_pkg::S_POLY: begin
        mul_a = {p[32], p};
        mul_b = $signed({3'b0, x2});
      end
      wpdb_pkg::S_Y: begin
        mul_a = {p[32], p};
        mul_b = $signed({3'b0, x});
      end
      wpdb_pkg::S_SQUARE: begin
        mul_a = {{(MW-SB){samp[SB-1]}}, samp};
        mul_b = {{(MW-SB){samp[SB-1]}}, samp};
      end
      wpdb_pkg::S_LOG_SQR: begin
        mul_a = $signed({2'b0, lm});
        mul_b = $signed({2'b0, lm});
      end
      wpdb_pkg::S_DB: begin
        mul_a = {{(MW-24){dlog[23]}}, dlog};
        mul_b = $signed(wpdb_pkg::DB_PER_BIT_Q24);
      end
      wpdb_pkg::S_IDLE, wpdb_pkg::S_LOG_NORM, wpdb_pkg::S_CMP, wpdb_pkg::S_MAP,
      wpdb_pkg::S_DIV, wpdb_pkg::S_LVL, wpdb_pkg::S_OUT: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Tone: table index, quadrant and reduced argument from the phase product, then the signed tone.
  logic [23:0]          ph;
  logic [LD-1:0]        tab_k;
  logic [29:0]          r30;
  logic [30:0]          x_c;
  logic signed [37:0]   qm;
  logic [31:0]          ycl;
  logic [63:0]          mag_sum;
  logic [63:0]          mag_v;
  logic [63:0]          mag;
  logic signed [SB-1:0] tone_c;

  always_comb begin
    ph      = prod[23:0];
    tab_k   = ph[23 -: LD];
    r30     = {tab_k[LD-3:0], {(32-LD){1'b0}}};
    x_c     = tab_k[LD-2] ? (31'h4000_0000 - {1'b0, r30}) : {1'b0, r30};
    qm      = wpdb_pkg::qmul_q30(prod);
    ycl     = qm[37] ? 32'd0 : qm[31:0];
    mag_sum = ({32'b0, ycl} << (SB - 1)) + 64'h2000_0000;
    mag_v   = mag_sum >> 30;
    mag     = (mag_v > TONE_FULL) ? TONE_FULL : mag_v;
    tone_c  = quad[1] ? -$signed(mag[SB-1:0]) : $signed(mag[SB-1:0]);
  end

  // Window bookkeeping from the square, and the tone index step.
  logic [61:0]   sq_sat;
  logic [WB-1:0] len_eff;
  logic [WB:0]   cnt;
  logic          win_end;
  logic [62:0]   sum_add;
  logic [61:0]   sum_next;
  logic [16:0]   idx_inc;

  always_comb begin
    sq_sat   = (|prod[63:62]) ? '1 : prod[61:0];
    len_eff  = (window_length == '0) ? WB'(1) : window_length;
    cnt      = {1'b0, window_count} + (WB+1)'(1);
    win_end  = (cnt >= {1'b0, len_eff});
    sum_add  = {1'b0, window_sum} + {1'b0, sq_sat};
    sum_next = sum_add[62] ? '1 : sum_add[61:0];
    idx_inc  = {1'b0, tone_index} + 17'd1;
  end

  // Leading-one search, one bisection step per cycle.
  logic        norm_hit;
  logic [63:0] norm_sh;
  logic [5:0]  norm_amt;
  logic [5:0]  zcnt_c;

  always_comb begin
    norm_hit = 1'b0;
    norm_sh  = norm;
    norm_amt = 6'd0;
    case (step)
      5'd0: begin norm_hit = (norm[63:32] == '0); norm_sh = norm << 32; norm_amt = 6'd32; end
      5'd1: begin norm_hit = (norm[63:48] == '0); norm_sh = norm << 16; norm_amt = 6'd16; end
      5'd2: begin norm_hit = (norm[63:56] == '0); norm_sh = norm << 8;  norm_amt = 6'd8;  end
      5'd3: begin norm_hit = (norm[63:60] == '0); norm_sh = norm << 4;  norm_amt = 6'd4;  end
      5'd4: begin norm_hit = (norm[63:62] == '0); norm_sh = norm << 2;  norm_amt = 6'd2;  end
      5'd5: begin norm_hit = (norm[63] == 1'b0);  norm_sh = norm << 1;  norm_amt = 6'd1;  end
      default: begin norm_hit = 1'b0; norm_sh = norm; norm_amt = 6'd0; end
    endcase
    if (!norm_hit) begin
      norm_sh  = norm;
      norm_amt = 6'd0;
    end
    zcnt_c = zcnt + norm_amt;
  end

  // Log squaring step and log result assembly.
  logic [32:0] t33;
  logic [21:0] log_c;
  assign t33   = prod[63:31];
  assign log_c = {nlog, frac[14:0], t33[32]};

  // dB scale, round and clamp.
  logic signed [PW-1:0] db_round;
  logic signed [35:0]   db_raw;
  logic signed [17:0]   db_c;

  always_comb begin
    db_round = prod + (68'sd1 <<< 31);
    db_raw   = db_round[67:32];
    if (db_raw < 36'sd0 - 36'sd131072) begin
      db_c = wpdb_pkg::DB_FLOOR;
    end else if (db_raw > 36'sd0) begin
      db_c = '0;
    end else begin
      db_c = db_raw[17:0];
    end
  end

  // Level map numerator and denominator, and the trivial cases that need no divide.
  logic signed [18:0] lo_x, hi_x, den, dlo;
  logic signed [29:0] num30, n30, d30;
  logic               map_trivial;
  logic [7:0]         map_lv;

  always_comb begin
    lo_x  = {lower_db[17], lower_db};
    hi_x  = {upper_db[17], upper_db};
    den   = hi_x - lo_x;
    dlo   = {db[17], db} - lo_x;
    num30 = ({{11{dlo[18]}}, dlo} <<< 8) - {{11{dlo[18]}}, dlo};
    n30   = (num30 <<< 1) + {{11{den[18]}}, den};
    d30   = {{11{den[18]}}, den} <<< 1;
    map_trivial = 1'b1;
    map_lv      = 8'd0;
    if (den <= 19'sd0) begin
      map_lv = (db >= lower_db) ? 8'd255 : 8'd0;
    end else if (num30 <= 30'sd0) begin
      map_lv = 8'd0;
    end else if (n30 >= (d30 <<< 8)) begin
      map_lv = 8'd255;
    end else begin
      map_trivial = 1'b0;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      wpdb_pkg::S_IDLE:     if (accept) state_next = wpdb_pkg::S_PHASE;
      wpdb_pkg::S_PHASE:    if (mul_wait) state_next = wpdb_pkg::S_X2;
      wpdb_pkg::S_X2:       if (mul_wait) state_next = wpdb_pkg::S_POLY;
      wpdb_pkg::S_POLY:     if (mul_wait && step == 5'd4) state_next = wpdb_pkg::S_Y;
      wpdb_pkg::S_Y:        if (mul_wait) state_next = wpdb_pkg::S_SQUARE;
      wpdb_pkg::S_SQUARE: begin
        if (mul_wait) begin
          if (!win_end) begin
            state_next = wpdb_pkg::S_OUT;
          end else if (window_sum == '0) begin
            state_next = wpdb_pkg::S_CMP;
          end else begin
            state_next = wpdb_pkg::S_LOG_NORM;
          end
        end
      end
      wpdb_pkg::S_LOG_NORM: if (step == 5'd5) state_next = wpdb_pkg::S_LOG_SQR;
      wpdb_pkg::S_LOG_SQR: begin
        if (mul_wait && step == 5'd15) begin
          state_next = log_sel ? wpdb_pkg::S_DB : wpdb_pkg::S_LOG_NORM;
        end
      end
      wpdb_pkg::S_DB:       if (mul_wait) state_next = wpdb_pkg::S_CMP;
      wpdb_pkg::S_CMP: begin
        if (db != last_db && !calibrate_mode) begin
          state_next = wpdb_pkg::S_MAP;
        end else begin
          state_next = wpdb_pkg::S_OUT;
        end
      end
      wpdb_pkg::S_MAP:      state_next = map_trivial ? wpdb_pkg::S_LVL : wpdb_pkg::S_DIV;
      wpdb_pkg::S_DIV:      if (step == 5'd7) state_next = wpdb_pkg::S_LVL;
      wpdb_pkg::S_LVL:      state_next = wpdb_pkg::S_OUT;
      wpdb_pkg::S_OUT:      if (out_free) state_next = wpdb_pkg::S_IDLE;
    endcase
  end

  // Registers and datapath.
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (rst) begin
      calibrate_mode  <= 1'b0;
      tone_phase_step <= 24'd153791;
      tone_period     <= 16'd109;
      window_length   <= WB'(109);
      lower_db        <= -18'sd23040;
      upper_db        <= -18'sd1536;
      tone_index      <= '0;
      window_count    <= '0;
      window_sum      <= '0;
      last_db         <= '0;
      last_level      <= '0;
      state           <= wpdb_pkg::S_IDLE;
      mul_wait        <= 1'b0;
      step            <= '0;
      result_valid    <= 1'b0;
      pend_db_valid   <= 1'b0;
      pend_lv_valid   <= 1'b0;
    end else begin
      state <= state_next;

      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          wpdb_pkg::CFG_CALIBRATE:  calibrate_mode  <= cfg_data[0];
          wpdb_pkg::CFG_PHASE_STEP: tone_phase_step <= cfg_data[23:0];
          wpdb_pkg::CFG_PERIOD:     tone_period     <= cfg_data[15:0];
          wpdb_pkg::CFG_WINDOW:     window_length   <= cfg_data[WB-1:0];
          wpdb_pkg::CFG_LOWER:      lower_db        <= $signed(cfg_data[17:0]);
          wpdb_pkg::CFG_UPPER:      upper_db        <= $signed(cfg_data[17:0]);
          default: ;
        endcase
      end

      // Result valid: set when a result is issued, cleared when it is taken.
      if (state == wpdb_pkg::S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      // Multiply states toggle mul_wait: the product is registered, then used.
      if (state == wpdb_pkg::S_PHASE || state == wpdb_pkg::S_X2 ||
          state == wpdb_pkg::S_POLY || state == wpdb_pkg::S_Y ||
          state == wpdb_pkg::S_SQUARE || state == wpdb_pkg::S_LOG_SQR ||
          state == wpdb_pkg::S_DB) begin
        mul_wait <= !mul_wait;
      end else begin
        mul_wait <= 1'b0;
      end

      unique case (state)
        wpdb_pkg::S_IDLE: begin
          if (accept) begin
            samp          <= return_sample;
            pend_db_valid <= 1'b0;
            pend_lv_valid <= 1'b0;
          end
        end
        wpdb_pkg::S_PHASE: begin
          if (mul_wait) begin
            quad <= tab_k[LD-1:LD-2];
            x    <= x_c;
          end
        end
        wpdb_pkg::S_X2: begin
          if (mul_wait) begin
            x2   <= qm[30:0];
            p    <= wpdb_pkg::POLY_COEF[0];
            step <= '0;
          end
        end
        wpdb_pkg::S_POLY: begin
          if (mul_wait) begin
            p    <= wpdb_pkg::POLY_COEF[step[2:0] + 3'd1] + $signed(qm[32:0]);
            step <= step + 5'd1;
          end
        end
        wpdb_pkg::S_Y: begin
          if (mul_wait) begin
            tone <= tone_c;
          end
        end
        wpdb_pkg::S_SQUARE: begin
          if (mul_wait) begin
            // Window end logs the sum before this sample and restarts with its square.
            if (win_end) begin
              norm         <= {2'b0, window_sum};
              zcnt         <= '0;
              step         <= '0;
              log_sel      <= 1'b0;
              db           <= wpdb_pkg::DB_FLOOR;
              window_sum   <= sq_sat;
              window_count <= '0;
            end else begin
              window_sum   <= sum_next;
              window_count <= cnt[WB-1:0];
            end
            if (tone_period != '0 && idx_inc >= {1'b0, tone_period}) begin
              tone_index <= '0;
            end else begin
              tone_index <= idx_inc[15:0];
            end
          end
        end
        wpdb_pkg::S_LOG_NORM: begin
          norm <= norm_sh;
          zcnt <= zcnt_c;
          if (step == 5'd5) begin
            lm   <= norm_sh[63:32];
            nlog <= 6'd63 - zcnt_c;
            frac <= '0;
            step <= '0;
          end else begin
            step <= step + 5'd1;
          end
        end
        wpdb_pkg::S_LOG_SQR: begin
          if (mul_wait) begin
            frac <= {frac[14:0], t33[32]};
            lm   <= t33[32] ? t33[32:1] : t33[31:0];
            if (step == 5'd15) begin
              step <= '0;
              if (!log_sel) begin
                // Second pass takes the window length.
                log_a   <= log_c;
                log_sel <= 1'b1;
                norm    <= {{(64-WB){1'b0}}, len_eff};
                zcnt    <= '0;
              end else begin
                dlog <= $signed({2'b0, log_a}) - $signed({2'b0, log_c}) - LOG_OFFSET;
              end
            end else begin
              step <= step + 5'd1;
            end
          end
        end
        wpdb_pkg::S_DB: begin
          if (mul_wait) begin
            db <= db_c;
          end
        end
        wpdb_pkg::S_CMP: begin
          if (db != last_db) begin
            last_db <= db;
            if (calibrate_mode) begin
              pend_db_valid <= 1'b1;
            end
          end
        end
        wpdb_pkg::S_MAP: begin
          lv   <= map_lv;
          rem  <= n30;
          dsh  <= d30 <<< 7;
          quo  <= '0;
          step <= '0;
        end
        wpdb_pkg::S_DIV: begin
          // Restoring divide, one quotient bit per cycle.
          if (rem >= dsh) begin
            rem <= rem - dsh;
            quo <= {quo[6:0], 1'b1};
            if (step == 5'd7) lv <= {quo[6:0], 1'b1};
          end else begin
            quo <= {quo[6:0], 1'b0};
            if (step == 5'd7) lv <= {quo[6:0], 1'b0};
          end
          dsh  <= dsh >> 1;
          step <= step + 5'd1;
        end
        wpdb_pkg::S_LVL: begin
          if (lv != last_level) begin
            last_level    <= lv;
            pend_lv_valid <= 1'b1;
          end
        end
        wpdb_pkg::S_OUT: begin
          if (out_free) begin
            tone_sample  <= tone;
            level_valid  <= pend_lv_valid;
            level        <= pend_lv_valid ? lv : 8'd0;
            db_valid     <= pend_db_valid;
            level_db     <= pend_db_valid ? db : 18'sd0;
          end
        end
      endcase
    end
  end

  // Checks on internal consistency.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(level_valid && db_valid))
    else $error("level and dB reported in the same transaction");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == wpdb_pkg::S_LOG_NORM |-> norm != '0)
    else $error("log2 of zero requested");

  a_mant_norm: assert property (@(posedge clk) disable iff (rst)
    state == wpdb_pkg::S_LOG_SQR |-> lm[31])
    else $error("log2 mantissa not normalized");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == wpdb_pkg::S_DIV |-> dsh != '0)
    else $error("level divide by zero");

endmodule
